@@ hw/rtl/hrcd_pkg.sv @@
// ----------------------------------------------------------------------------
// hrcd_pkg
// Shared types, constants and helpers of the chunked response deframer.
// ----------------------------------------------------------------------------
`default_nettype none
package hrcd_pkg;

  localparam int HEX_LINE_MAX_DEF     = 16;
  localparam int STATUS_LINE_KEEP_DEF = 63;
  localparam int HEADER_LINE_KEEP_DEF = 31;

  localparam logic [23:0] SIZE_LIMIT_RESET = 24'd614400;
  localparam int TE_LEN   = 18;
  localparam int CL_LEN   = 15;
  localparam int WORD_LEN = 7;
  localparam int QDEPTH   = 4;

  typedef enum logic [2:0] {
    PH_STATUS  = 3'd0,
    PH_HEADERS = 3'd1,
    PH_PLAIN   = 3'd2,
    PH_CSIZE   = 3'd3,
    PH_CDATA   = 3'd4,
    PH_CCR     = 3'd5,
    PH_CLF     = 3'd6,
    PH_DONE    = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_NO_HDR   = 3'd1,
    ERR_FRAMING  = 3'd2,
    ERR_TRUNC    = 3'd3,
    ERR_OVERSIZE = 3'd4
  } err_t;

  localparam logic [1:0] REG_SIZE_LIMIT = 2'd0;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        end_of_response;
    logic [9:0]  status_code;
    logic [2:0]  error_code;
    logic [23:0] body_length;
  } out_item_t;

  // job handed from front to back: an optional body byte and an optional summary
  typedef struct packed {
    logic        has_byte;
    logic [7:0]  data;
    logic        has_sum;
    logic [9:0]  status;
    logic [2:0]  err;
    logic [23:0] len;
  } job_t;

  function automatic logic [7:0] lower(input logic [7:0] c);
    lower = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    is_space = (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic logic [7:0] te_char(input logic [4:0] p);
    case (p)
      5'd0: te_char = "t";  5'd1: te_char = "r";  5'd2: te_char = "a";
      5'd3: te_char = "n";  5'd4: te_char = "s";  5'd5: te_char = "f";
      5'd6: te_char = "e";  5'd7: te_char = "r";  5'd8: te_char = "-";
      5'd9: te_char = "e";  5'd10: te_char = "n"; 5'd11: te_char = "c";
      5'd12: te_char = "o"; 5'd13: te_char = "d"; 5'd14: te_char = "i";
      5'd15: te_char = "n"; 5'd16: te_char = "g"; 5'd17: te_char = ":";
      default: te_char = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] cl_char(input logic [3:0] p);
    case (p)
      4'd0: cl_char = "c";  4'd1: cl_char = "o";  4'd2: cl_char = "n";
      4'd3: cl_char = "t";  4'd4: cl_char = "e";  4'd5: cl_char = "n";
      4'd6: cl_char = "t";  4'd7: cl_char = "-";  4'd8: cl_char = "l";
      4'd9: cl_char = "e";  4'd10: cl_char = "n"; 4'd11: cl_char = "g";
      4'd12: cl_char = "t"; 4'd13: cl_char = "h"; 4'd14: cl_char = ":";
      default: cl_char = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] word_char(input logic [2:0] p);
    case (p)
      3'd0: word_char = "c"; 3'd1: word_char = "h"; 3'd2: word_char = "u";
      3'd3: word_char = "n"; 3'd4: word_char = "k"; 3'd5: word_char = "e";
      3'd6: word_char = "d";
      default: word_char = 8'h00;
    endcase
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/hrcd_front.sv @@
// ----------------------------------------------------------------------------
// hrcd_front
// Per-byte parser: status line, headers, chunk framing; issues one job a byte.
// ----------------------------------------------------------------------------
`default_nettype none
module hrcd_front #(
  parameter int HEX_LINE_MAX     = hrcd_pkg::HEX_LINE_MAX_DEF,
  parameter int STATUS_LINE_KEEP = hrcd_pkg::STATUS_LINE_KEEP_DEF,
  parameter int HEADER_LINE_KEEP = hrcd_pkg::HEADER_LINE_KEEP_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  fire,
  input  hrcd_pkg::in_item_t   item,
  input  wire  [23:0]          size_limit,
  output hrcd_pkg::job_t       job
);

  localparam logic [7:0] SKEEP = 8'(STATUS_LINE_KEEP);
  localparam logic [7:0] HKEEP = 8'(HEADER_LINE_KEEP);
  localparam logic [5:0] HMAX  = 6'(HEX_LINE_MAX);

  hrcd_pkg::phase_t phase, phase_next;
  logic [1:0]  blank_line_match, blank_line_match_next;
  logic [7:0]  line_position, line_position_next;
  logic [9:0]  status_value, status_value_next;
  logic [1:0]  status_flags, status_flags_next;
  logic [1:0]  header_prefix_flags, header_prefix_flags_next;
  logic        chunked_seen, chunked_seen_next;
  logic [2:0]  chunked_word_match, chunked_word_match_next;
  logic [31:0] length_value, length_value_next;
  logic [1:0]  length_parse_flags, length_parse_flags_next;
  logic [31:0] chunk_remaining, chunk_remaining_next;
  logic [5:0]  size_line_length, size_line_length_next;
  logic        hex_stopped, hex_stopped_next;
  logic [23:0] raw_count, raw_count_next;
  logic [23:0] body_count, body_count_next;
  logic [2:0]  error_state, error_state_next;

  // per-byte parse
  always_comb begin
    logic [7:0]  c, lc;
    logic [1:0]  m;
    logic [3:0]  d;
    logic [4:0]  hd;
    logic [13:0] sv;
    logic [35:0] lv;
    logic [2:0]  err;
    logic [5:0]  sl;
    c = item.in_byte;
    lc = hrcd_pkg::lower(c);
    m = blank_line_match;
    d = 4'(c - 8'h30);
    hd = 5'd16;
    sv = 14'd0;
    lv = 36'd0;
    err = 3'd0;
    sl = 6'd0;
    phase_next = phase;
    blank_line_match_next = blank_line_match;
    line_position_next = line_position;
    status_value_next = status_value;
    status_flags_next = status_flags;
    header_prefix_flags_next = header_prefix_flags;
    chunked_seen_next = chunked_seen;
    chunked_word_match_next = chunked_word_match;
    length_value_next = length_value;
    length_parse_flags_next = length_parse_flags;
    chunk_remaining_next = chunk_remaining;
    size_line_length_next = size_line_length;
    hex_stopped_next = hex_stopped;
    raw_count_next = raw_count;
    body_count_next = body_count;
    error_state_next = error_state;
    job = '0;
    job.data = c;

    if (raw_count >= size_limit) begin
      error_state_next = hrcd_pkg::ERR_OVERSIZE;
      phase_next = hrcd_pkg::PH_DONE;
    end else begin
      raw_count_next = raw_count + 24'd1;
      case (phase)
        hrcd_pkg::PH_STATUS, hrcd_pkg::PH_HEADERS: begin
          if (c == 8'd13) blank_line_match_next = (m == 2'd2) ? 2'd3 : 2'd1;
          else if (c == 8'd10 && m == 2'd1) blank_line_match_next = 2'd2;
          else blank_line_match_next = 2'd0;
          if (c == 8'd10 && m == 2'd3 && phase == hrcd_pkg::PH_HEADERS) begin
            blank_line_match_next = 2'd0;
            phase_next = chunked_seen ? hrcd_pkg::PH_CSIZE : hrcd_pkg::PH_PLAIN;
          end else if (c == 8'd10 && m == 2'd1) begin
            if (phase == hrcd_pkg::PH_HEADERS && header_prefix_flags[0] &&
                chunked_word_match == 3'(hrcd_pkg::WORD_LEN) &&
                line_position > 8'(hrcd_pkg::TE_LEN))
              chunked_seen_next = 1'b1;
            phase_next = hrcd_pkg::PH_HEADERS;
            line_position_next = 8'd0;
            header_prefix_flags_next = 2'b11;
            chunked_word_match_next = 3'd0;
            if (length_parse_flags == 2'd3) length_parse_flags_next = 2'd2;
          end else if (phase == hrcd_pkg::PH_STATUS) begin
            if (line_position < SKEEP) begin
              case (status_flags)
                2'd0: begin
                  if (c == 8'h20) status_flags_next = 2'd1;
                  else if (c == 8'h00) status_flags_next = 2'd3;
                end
                2'd1: begin
                  if (hrcd_pkg::is_digit(c)) begin
                    status_value_next = 10'(d);
                    status_flags_next = 2'd2;
                  end else if (c == 8'h2b) status_flags_next = 2'd2;
                  else if (!hrcd_pkg::is_space(c)) status_flags_next = 2'd3;
                end
                2'd2: begin
                  if (hrcd_pkg::is_digit(c)) begin
                    sv = 14'(status_value) * 14'd10 + 14'(d);
                    status_value_next = (sv > 14'd999) ? 10'd999 : sv[9:0];
                  end else status_flags_next = 2'd3;
                end
                default: ;
              endcase
            end
            if (line_position != 8'd255) line_position_next = line_position + 8'd1;
          end else begin
            if (line_position < 8'(hrcd_pkg::TE_LEN) &&
                lc != hrcd_pkg::te_char(line_position[4:0]))
              header_prefix_flags_next[0] = 1'b0;
            if (line_position < 8'(hrcd_pkg::CL_LEN)) begin
              if (lc != hrcd_pkg::cl_char(line_position[3:0]))
                header_prefix_flags_next[1] = 1'b0;
              else if (line_position == 8'(hrcd_pkg::CL_LEN - 1) &&
                       header_prefix_flags_next[1]) begin
                length_value_next = 32'd0;
                length_parse_flags_next = 2'd0;
              end
            end else if (header_prefix_flags[1] && line_position < HKEEP) begin
              case (length_parse_flags)
                2'd0: begin
                  if (hrcd_pkg::is_digit(c)) begin
                    length_value_next = 32'(d);
                    length_parse_flags_next = 2'd1;
                  end else if (c == 8'h2b) length_parse_flags_next = 2'd1;
                  else if (c == 8'h2d) begin
                    length_value_next = 32'd0;
                    length_parse_flags_next = 2'd3;
                  end else if (!hrcd_pkg::is_space(c)) length_parse_flags_next = 2'd2;
                end
                2'd1: begin
                  if (hrcd_pkg::is_digit(c)) begin
                    lv = 36'(length_value) * 36'd10 + 36'(d);
                    length_value_next = (lv[35:32] != 4'd0) ? 32'hffffffff : lv[31:0];
                  end else length_parse_flags_next = 2'd2;
                end
                default: ;
              endcase
            end
            if (chunked_word_match < 3'(hrcd_pkg::WORD_LEN)) begin
              if (lc == hrcd_pkg::word_char(chunked_word_match))
                chunked_word_match_next = chunked_word_match + 3'd1;
              else chunked_word_match_next = (lc == 8'h63) ? 3'd1 : 3'd0;
            end
            if (line_position != 8'd255) line_position_next = line_position + 8'd1;
          end
        end
        hrcd_pkg::PH_PLAIN: begin
          if (length_value == 32'd0 || {8'd0, body_count} < length_value) begin
            job.has_byte = 1'b1;
            body_count_next = body_count + 24'd1;
          end
        end
        hrcd_pkg::PH_CSIZE: begin
          if (c == 8'd10 && blank_line_match == 2'd1) begin
            sl = size_line_length - 6'd1;
            blank_line_match_next = 2'd0;
            size_line_length_next = 6'd0;
            hex_stopped_next = 1'b0;
            if (sl == 6'd0 || sl > HMAX) begin
              error_state_next = hrcd_pkg::ERR_FRAMING;
              phase_next = hrcd_pkg::PH_DONE;
            end else if (chunk_remaining == 32'd0) phase_next = hrcd_pkg::PH_DONE;
            else phase_next = hrcd_pkg::PH_CDATA;
          end else begin
            size_line_length_next = size_line_length + 6'd1;
            if (size_line_length_next > HMAX + 6'd1) begin
              error_state_next = hrcd_pkg::ERR_FRAMING;
              phase_next = hrcd_pkg::PH_DONE;
            end else begin
              if (!hex_stopped) begin
                if (hrcd_pkg::is_digit(c)) hd = {1'b0, d};
                else if (lc >= 8'h61 && lc <= 8'h66) hd = 5'(lc - 8'h57);
                if (!hd[4])
                  chunk_remaining_next = (chunk_remaining > 32'h0fffffff) ?
                    32'hffffffff : {chunk_remaining[27:0], hd[3:0]};
                else hex_stopped_next = 1'b1;
              end
              blank_line_match_next = (c == 8'd13) ? 2'd1 : 2'd0;
            end
          end
        end
        hrcd_pkg::PH_CDATA: begin
          job.has_byte = 1'b1;
          body_count_next = body_count + 24'd1;
          chunk_remaining_next = chunk_remaining - 32'd1;
          if (chunk_remaining == 32'd1) phase_next = hrcd_pkg::PH_CCR;
        end
        hrcd_pkg::PH_CCR: begin
          if (c == 8'd13) phase_next = hrcd_pkg::PH_CLF;
          else begin
            error_state_next = hrcd_pkg::ERR_FRAMING;
            phase_next = hrcd_pkg::PH_DONE;
          end
        end
        hrcd_pkg::PH_CLF: begin
          if (c == 8'd10) phase_next = hrcd_pkg::PH_CSIZE;
          else begin
            error_state_next = hrcd_pkg::ERR_FRAMING;
            phase_next = hrcd_pkg::PH_DONE;
          end
        end
        default: ;
      endcase
    end

    // end of response summary
    case (phase_next)
      hrcd_pkg::PH_STATUS, hrcd_pkg::PH_HEADERS: err = hrcd_pkg::ERR_NO_HDR;
      hrcd_pkg::PH_CSIZE:
        err = (size_line_length_next != 6'd0) ? hrcd_pkg::ERR_FRAMING : hrcd_pkg::ERR_OK;
      hrcd_pkg::PH_CDATA: err = hrcd_pkg::ERR_TRUNC;
      hrcd_pkg::PH_CCR, hrcd_pkg::PH_CLF: err = hrcd_pkg::ERR_FRAMING;
      hrcd_pkg::PH_PLAIN: err = hrcd_pkg::ERR_OK;
      default: err = error_state_next;
    endcase
    job.has_sum = item.in_last;
    job.err = err;
    job.status = (err == hrcd_pkg::ERR_NO_HDR || err == hrcd_pkg::ERR_OVERSIZE) ?
                 10'd0 : status_value_next;
    job.len = body_count_next;
  end

  // parser state; a summary returns everything to reset
  always_ff @(posedge clk) begin
    if (rst || (fire && item.in_last)) begin
      phase <= hrcd_pkg::PH_STATUS;
      blank_line_match <= '0;
      line_position <= '0;
      status_value <= '0;
      status_flags <= '0;
      header_prefix_flags <= 2'b11;
      chunked_seen <= 1'b0;
      chunked_word_match <= '0;
      length_value <= '0;
      length_parse_flags <= '0;
      chunk_remaining <= '0;
      size_line_length <= '0;
      hex_stopped <= 1'b0;
      raw_count <= '0;
      body_count <= '0;
      error_state <= '0;
    end else if (fire) begin
      phase <= phase_next;
      blank_line_match <= blank_line_match_next;
      line_position <= line_position_next;
      status_value <= status_value_next;
      status_flags <= status_flags_next;
      header_prefix_flags <= header_prefix_flags_next;
      chunked_seen <= chunked_seen_next;
      chunked_word_match <= chunked_word_match_next;
      length_value <= length_value_next;
      length_parse_flags <= length_parse_flags_next;
      chunk_remaining <= chunk_remaining_next;
      size_line_length <= size_line_length_next;
      hex_stopped <= hex_stopped_next;
      raw_count <= raw_count_next;
      body_count <= body_count_next;
      error_state <= error_state_next;
    end
  end

  // chunk data phase never runs with nothing left
  a_cdata_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == hrcd_pkg::PH_CDATA |-> chunk_remaining != 32'd0)
    else $error("chunk data phase with zero remaining");
  // no body byte is emitted once the raw count reaches the limit
  a_raw_bound: assert property (@(posedge clk) disable iff (rst)
    fire && raw_count >= size_limit |-> job.has_byte == 1'b0)
    else $error("byte emitted past size limit");
  // phase and raw count clear after a summary
  a_clear: assert property (@(posedge clk) disable iff (rst)
    fire && item.in_last |=> phase == hrcd_pkg::PH_STATUS && raw_count == 24'd0)
    else $error("state not cleared after summary");

endmodule
`default_nettype wire

@@ hw/rtl/hrcd_back.sv @@
// ----------------------------------------------------------------------------
// hrcd_back
// Job queue and result sequencer: splits each job into one or two items.
// ----------------------------------------------------------------------------
`default_nettype none
module hrcd_back (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  hrcd_pkg::job_t       job,
  output logic                 full,
  output logic                 out_valid,
  input  wire                  out_stall,
  output hrcd_pkg::out_item_t  out_item
);

  localparam int AW = $clog2(hrcd_pkg::QDEPTH);

  hrcd_pkg::job_t q [hrcd_pkg::QDEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [AW:0]   count;
  logic          byte_done;
  hrcd_pkg::job_t head;
  logic          pop, take;
  logic          empty;

  // skip jobs that carry nothing
  logic push_real;
  assign push_real = push && (job.has_byte || job.has_sum);
  assign empty = (count == '0);
  assign full  = (count == (AW+1)'(hrcd_pkg::QDEPTH));
  assign head  = q[rptr];

  always_comb begin
    out_item = '0;
    if (head.has_byte && !byte_done) begin
      out_item.out_byte = head.data;
      out_item.byte_valid = 1'b1;
    end else begin
      out_item.end_of_response = 1'b1;
      out_item.status_code = head.status;
      out_item.error_code = head.err;
      out_item.body_length = head.len;
    end
  end

  assign out_valid = !empty;
  assign take = out_valid && !out_stall;
  assign pop = take && (!(head.has_byte && !byte_done) || !head.has_sum);

  // queue storage
  always_ff @(posedge clk) begin
    if (push_real) q[wptr] <= job;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
      byte_done <= 1'b0;
    end else begin
      if (push_real) wptr <= wptr + AW'(1);
      if (pop) rptr <= rptr + AW'(1);
      count <= count + (AW+1)'(push_real) - (AW+1)'(pop);
      if (pop) byte_done <= 1'b0;
      else if (take) byte_done <= 1'b1;
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (rst) full |-> !push_real)
    else $error("queue overflow");
  a_split: assert property (@(posedge clk) disable iff (rst)
    take && !pop |=> byte_done && !empty)
    else $error("split job lost");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(hrcd_pkg::QDEPTH))
    else $error("count out of range");

endmodule
`default_nettype wire

@@ hw/rtl/http_response_chunked_deframer.sv @@
// ----------------------------------------------------------------------------
// http_response_chunked_deframer
// HTTP/1.1 chunked response parser; one byte per cycle while in_stall is low.
// ----------------------------------------------------------------------------
//  channel  | direction | payload     | handshake
//  in       | input     | in_item_t   | in_valid / in_stall
//  out      | output    | out_item_t  | out_valid / out_stall
//  cfg      | input     | size_limit  | APB psel/penable/pwrite
//
// One input byte is accepted per cycle while in_stall is low; the front
// parser registers its state update, and its job is written into the queue,
// whose head offers its items. A last byte with a body byte yields two output
// items, the byte first and then the summary. Reset clears the parser and
// queue. in_stall rises while the four-entry job queue is full.
// ----------------------------------------------------------------------------
`default_nettype none
module http_response_chunked_deframer #(
  parameter int HEX_LINE_MAX     = hrcd_pkg::HEX_LINE_MAX_DEF,
  parameter int STATUS_LINE_KEEP = hrcd_pkg::STATUS_LINE_KEEP_DEF,
  parameter int HEADER_LINE_KEEP = hrcd_pkg::HEADER_LINE_KEEP_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  hrcd_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  wire                  out_stall,
  output hrcd_pkg::out_item_t  out_item,
  input  wire                  psel,
  input  wire                  penable,
  input  wire                  pwrite,
  input  wire  [1:0]           paddr,
  input  wire  [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [23:0] size_limit;
  logic fire, full;
  hrcd_pkg::job_t job;

  assign pready = 1'b1;
  assign prdata = (paddr[1:0] == hrcd_pkg::REG_SIZE_LIMIT) ? {8'd0, size_limit} : 32'd0;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) size_limit <= hrcd_pkg::SIZE_LIMIT_RESET;
    else if (psel && penable && pwrite && paddr == hrcd_pkg::REG_SIZE_LIMIT)
      size_limit <= pwdata[23:0];
  end

  assign in_stall = full;
  assign fire = in_valid && !full;

  hrcd_front #(
    .HEX_LINE_MAX(HEX_LINE_MAX),
    .STATUS_LINE_KEEP(STATUS_LINE_KEEP),
    .HEADER_LINE_KEEP(HEADER_LINE_KEEP)
  ) u_front (
    .clk(clk), .rst(rst), .fire(fire), .item(in_item),
    .size_limit(size_limit), .job(job)
  );

  hrcd_back u_back (
    .clk(clk), .rst(rst), .push(fire), .job(job), .full(full),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

endmodule
`default_nettype wire
